@@ design/qdf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdf_pkg: shared types and constants of the quadrature downmix FIR
// Item and result layouts, action codes, sequencer states, MAC control.
// ----------------------------------------------------------------------------
package qdf_pkg;

	// filter length and derived widths
	localparam int unsigned TAPS      = 32;
	localparam int unsigned TAP_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int unsigned CNT_W     = $clog2(TAPS + 3);

	// sine table
	localparam int unsigned SINE_LEN  = 32;
	localparam int unsigned PHASE_W   = 5;
	localparam logic [PHASE_W-1:0] COS_OFFSET = 5'd8;
	localparam logic [PHASE_W-1:0] STEP_RESET = 5'd6;

	// rounding constant
	localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

	// sequencer step counts: operand issue length and completion count
	localparam logic [CNT_W-1:0] MIX_LEN  = CNT_W'(1);
	localparam logic [CNT_W-1:0] MIX_DONE = CNT_W'(1 + 2);
	localparam logic [CNT_W-1:0] FIR_LEN  = CNT_W'(TAPS);
	localparam logic [CNT_W-1:0] FIR_DONE = CNT_W'(TAPS + 2);

	// action codes
	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_SINE   = 2'd1;
	localparam logic [1:0] ACT_TAP    = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] sample;
		logic [5:0]         table_index;
		logic signed [15:0] table_value;
	} item_t;

	typedef struct packed {
		logic signed [15:0] real_out;
		logic signed [15:0] imag_out;
	} result_t;

	// control for one MAC operation
	typedef struct packed {
		logic en;
		logic first;
		logic neg;
	} mac_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX_I,
		ST_MIX_Q,
		ST_FIR_I,
		ST_FIR_Q,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

@@ design/quadrature_downmix_decimating_fir.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_downmix_decimating_fir: quadrature mixer with decimating FIR
// Mixes real samples with a table carrier, filters I and Q with one shared
// tap set through a single MAC, and emits on every other sample.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  item      item_valid/item_stall  item (action, sample, table_index, value)
//  result    result_valid/stall     result (real_out, imag_out)
//  cfg       cfg_valid/cfg_ready    cfg_data (phase_step)
//
// a sample without a result runs the two mix steps only; a sample with one
// also runs both filters, the single MAC stepping through them one tap a
// cycle.
// reset clears the delay lines, phase and decimation flag; tables hold
// garbage until loaded. a result waits in the output register while the next
// item is taken; item_stall is high while a sample is in work.
// ----------------------------------------------------------------------------
module quadrature_downmix_decimating_fir (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire qdf_pkg::item_t        item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output qdf_pkg::result_t           result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [4:0]            cfg_data
);

	qdf_pkg::state_t                  state_q, state_d;
	logic [qdf_pkg::CNT_W-1:0]        cnt_q;
	logic [qdf_pkg::PHASE_W-1:0]      step_q;
	logic [qdf_pkg::PHASE_W-1:0]      phase_q;
	logic                             emit_q;
	logic signed [15:0]               sample_q;
	logic [15:0]                      ival_q;
	logic [15:0]                      real_res_q;
	logic [15:0]                      imag_res_q;
	qdf_pkg::result_t                 result_q;
	logic                             result_valid_q;
	qdf_pkg::mac_op_t                 op_q;

	logic                             item_acc;
	logic                             out_free;
	logic                             step_done;
	logic                             issue;
	logic                             mix_i_done;
	logic                             push;
	logic                             fir_i_done;
	logic                             fir_q_done;
	logic                             load_out;
	logic                             fir_state;
	logic [qdf_pkg::CNT_W-1:0]        issue_len;
	logic [qdf_pkg::CNT_W-1:0]        done_cnt;

	logic                             sine_we;
	logic                             tap_we;
	logic [qdf_pkg::PHASE_W-1:0]      sine_raddr;
	logic [qdf_pkg::TAP_IDX_W-1:0]    tap_idx;
	logic [15:0]                      sine_rdata;
	logic [15:0]                      tap_rdata;
	logic [15:0]                      line_rdata;
	logic signed [15:0]               mac_a;
	logic signed [15:0]               mac_b;
	logic [15:0]                      rnd;

	// handshakes
	assign item_stall   = (state_q != qdf_pkg::ST_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !(result_valid_q && result_stall);

	// table writes from load transactions
	assign sine_we = item_acc && (item.action == qdf_pkg::ACT_SINE) &&
		(7'(item.table_index) < 7'(qdf_pkg::SINE_LEN));
	assign tap_we  = item_acc && (item.action == qdf_pkg::ACT_TAP) &&
		(7'(item.table_index) < 7'(qdf_pkg::TAPS));

	// per-state step lengths
	always_comb begin
		fir_state = (state_q == qdf_pkg::ST_FIR_I) || (state_q == qdf_pkg::ST_FIR_Q);
		issue_len = fir_state ? qdf_pkg::FIR_LEN : qdf_pkg::MIX_LEN;
		done_cnt  = fir_state ? qdf_pkg::FIR_DONE : qdf_pkg::MIX_DONE;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			qdf_pkg::ST_IDLE: begin
				if (item_acc && (item.action == qdf_pkg::ACT_SAMPLE)) begin
					state_d = qdf_pkg::ST_MIX_I;
				end
			end
			qdf_pkg::ST_MIX_I: begin
				if (cnt_q == done_cnt) begin
					state_d = qdf_pkg::ST_MIX_Q;
				end
			end
			qdf_pkg::ST_MIX_Q: begin
				if (cnt_q == done_cnt) begin
					state_d = emit_q ? qdf_pkg::ST_FIR_I : qdf_pkg::ST_IDLE;
				end
			end
			qdf_pkg::ST_FIR_I: begin
				if (cnt_q == done_cnt) begin
					state_d = qdf_pkg::ST_FIR_Q;
				end
			end
			qdf_pkg::ST_FIR_Q: begin
				if (cnt_q == done_cnt) begin
					state_d = qdf_pkg::ST_OUT;
				end
			end
			qdf_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = qdf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = qdf_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		step_done  = 1'b0;
		issue      = 1'b0;
		mix_i_done = 1'b0;
		push       = 1'b0;
		fir_i_done = 1'b0;
		fir_q_done = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			qdf_pkg::ST_MIX_I: begin
				issue      = (cnt_q < issue_len);
				step_done  = (cnt_q == done_cnt);
				mix_i_done = step_done;
			end
			qdf_pkg::ST_MIX_Q: begin
				issue     = (cnt_q < issue_len);
				step_done = (cnt_q == done_cnt);
				push      = step_done;
			end
			qdf_pkg::ST_FIR_I: begin
				issue      = (cnt_q < issue_len);
				step_done  = (cnt_q == done_cnt);
				fir_i_done = step_done;
			end
			qdf_pkg::ST_FIR_Q: begin
				issue      = (cnt_q < issue_len);
				step_done  = (cnt_q == done_cnt);
				fir_q_done = step_done;
			end
			qdf_pkg::ST_OUT: begin
				load_out = out_free;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qdf_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (step_done || (state_q == qdf_pkg::ST_IDLE) ||
				(state_q == qdf_pkg::ST_OUT)) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// configuration, carrier phase and decimation flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= qdf_pkg::STEP_RESET;
			phase_q <= '0;
			emit_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				step_q <= cfg_data;
			end
			if (push) begin
				phase_q <= phase_q + step_q;
				emit_q  <= !emit_q;
			end
		end
	end

	// mac operation registered alongside the registered table read of its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= '0;
		end else begin
			op_q.en    <= issue;
			op_q.first <= (cnt_q == '0);
			op_q.neg   <= (state_q == qdf_pkg::ST_MIX_Q);
		end
	end

	// payload captures
	always_ff @(posedge clk) begin
		if (item_acc) begin
			sample_q <= item.sample;
		end
		if (mix_i_done) begin
			ival_q <= rnd;
		end
		if (fir_i_done) begin
			real_res_q <= rnd;
		end
		if (fir_q_done) begin
			imag_res_q <= rnd;
		end
		if (load_out) begin
			result_q.real_out <= real_res_q;
			result_q.imag_out <= imag_res_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_valid_q && !result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// read addresses
	always_comb begin
		if (state_q == qdf_pkg::ST_MIX_I) begin
			sine_raddr = phase_q + qdf_pkg::COS_OFFSET;
		end else begin
			sine_raddr = phase_q;
		end
		if (cnt_q < qdf_pkg::FIR_LEN) begin
			tap_idx = cnt_q[qdf_pkg::TAP_IDX_W-1:0];
		end else begin
			tap_idx = '0;
		end
	end

	// mac operand select
	always_comb begin
		if (fir_state) begin
			mac_a = line_rdata;
			mac_b = tap_rdata;
		end else begin
			mac_a = sample_q;
			mac_b = sine_rdata;
		end
	end

	qdf_store u_store (
		.clk        (clk),
		.wdata      (item.table_value),
		.sine_we    (sine_we),
		.sine_waddr (item.table_index[qdf_pkg::PHASE_W-1:0]),
		.sine_raddr (sine_raddr),
		.sine_rdata (sine_rdata),
		.tap_we     (tap_we),
		.tap_waddr  (item.table_index[qdf_pkg::TAP_IDX_W-1:0]),
		.tap_raddr  (tap_idx),
		.tap_rdata  (tap_rdata)
	);

	qdf_delay u_delay (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.real_in (ival_q),
		.imag_in (rnd),
		.rd_idx  (tap_idx),
		.rd_sel  (state_q == qdf_pkg::ST_FIR_Q),
		.rd_data (line_rdata)
	);

	qdf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_q),
		.a      (mac_a),
		.b      (mac_b),
		.rnd    (rnd)
	);

endmodule
`default_nettype wire

@@ design/qdf_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdf_mac: shared multiply-accumulate unit
// Registered 16x16 product, then 32-bit wrapping accumulate of +/- 2*a*b,
// with the rounded upper half as result.
// ----------------------------------------------------------------------------
module qdf_mac (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qdf_pkg::mac_op_t   op,
	input  wire logic signed [15:0] a,
	input  wire logic signed [15:0] b,
	output logic [15:0]             rnd
);

	qdf_pkg::mac_op_t   op_s1;
	logic signed [31:0] prod_s1;
	logic [31:0]        acc_q;
	logic [31:0]        dbl;
	logic [31:0]        term;
	logic [31:0]        rsum;

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	// product stage
	always_ff @(posedge clk) begin
		prod_s1 <= 32'(a * b);
	end

	// doubled and optionally negated term
	always_comb begin
		dbl  = {prod_s1[30:0], 1'b0};
		term = op_s1.neg ? (32'd0 - dbl) : dbl;
	end

	// accumulator
	always_ff @(posedge clk) begin
		if (op_s1.en) begin
			acc_q <= op_s1.first ? term : (acc_q + term);
		end
	end

	// round to the upper 16 bits
	always_comb begin
		rsum = acc_q + qdf_pkg::ROUND_HALF;
		rnd  = rsum[31:16];
	end

endmodule
`default_nettype wire

@@ design/qdf_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdf_store: sine table and filter tap memories
// One write and one registered read port per memory.
// ----------------------------------------------------------------------------
module qdf_store (
	input  wire logic                            clk,
	input  wire logic [15:0]                     wdata,
	input  wire logic                            sine_we,
	input  wire logic [qdf_pkg::PHASE_W-1:0]     sine_waddr,
	input  wire logic [qdf_pkg::PHASE_W-1:0]     sine_raddr,
	output logic [15:0]                          sine_rdata,
	input  wire logic                            tap_we,
	input  wire logic [qdf_pkg::TAP_IDX_W-1:0]   tap_waddr,
	input  wire logic [qdf_pkg::TAP_IDX_W-1:0]   tap_raddr,
	output logic [15:0]                          tap_rdata
);

	logic [15:0] sine_mem [qdf_pkg::SINE_LEN];
	logic [15:0] tap_mem  [qdf_pkg::TAPS];

	// sine table
	always_ff @(posedge clk) begin
		if (sine_we) begin
			sine_mem[sine_waddr] <= wdata;
		end
		sine_rdata <= sine_mem[sine_raddr];
	end

	// tap table
	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_mem[tap_waddr] <= wdata;
		end
		tap_rdata <= tap_mem[tap_raddr];
	end

endmodule
`default_nettype wire

@@ design/qdf_delay.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdf_delay: in-phase and quadrature delay lines
// Shift registers cleared by reset, index 0 newest, one registered read.
// ----------------------------------------------------------------------------
module qdf_delay (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic [15:0]                   real_in,
	input  wire logic [15:0]                   imag_in,
	input  wire logic [qdf_pkg::TAP_IDX_W-1:0] rd_idx,
	input  wire logic                          rd_sel,
	output logic [15:0]                        rd_data
);

	logic [15:0] real_line_q [qdf_pkg::TAPS];
	logic [15:0] imag_line_q [qdf_pkg::TAPS];

	// shift in the newest mixed values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qdf_pkg::TAPS; i++) begin
				real_line_q[i] <= '0;
				imag_line_q[i] <= '0;
			end
		end else if (push) begin
			real_line_q[0] <= real_in;
			imag_line_q[0] <= imag_in;
			for (int i = 1; i < qdf_pkg::TAPS; i++) begin
				real_line_q[i] <= real_line_q[i-1];
				imag_line_q[i] <= imag_line_q[i-1];
			end
		end
	end

	// registered tap read
	always_ff @(posedge clk) begin
		rd_data <= rd_sel ? imag_line_q[rd_idx] : real_line_q[rd_idx];
	end

endmodule
`default_nettype wire
